// ===== sv/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types, constants and the LFO coefficient table for the comb reverb.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int LINE_BITS    = 14;
	localparam int LINE_DEPTH   = 1 << LINE_BITS;
	localparam int SINE_BITS    = 10;
	localparam int SINE_ENTRIES = 1 << SINE_BITS;
	localparam int BRANCHES     = 4;
	localparam int BR_BITS      = 2;
	localparam int PHASE_BITS   = 24;
	localparam int ADDR_BITS    = BR_BITS + LINE_BITS;

	localparam logic [63:0] DELAYS_RESET = 64'd124129565377037753;
	localparam logic [14:0] FB_RESET     = 15'd16384;
	localparam logic [14:0] LPB_RESET    = 15'd16384;
	localparam logic [14:0] NORM_RESET   = 15'd21845;
	localparam logic [14:0] GAIN_RESET   = 15'd0;

	localparam logic [2:0] REG_DELAYS = 3'd0;
	localparam logic [2:0] REG_STEPS  = 3'd1;
	localparam logic [2:0] REG_FB     = 3'd2;
	localparam logic [2:0] REG_LPB    = 3'd3;
	localparam logic [2:0] REG_NORM   = 3'd4;
	localparam logic [2:0] REG_GAIN   = 3'd5;

	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_ACCEPT = 4'd1;
	localparam logic [3:0] OP_RD0    = 4'd2;
	localparam logic [3:0] OP_RD1    = 4'd3;
	localparam logic [3:0] OP_M1     = 4'd4;
	localparam logic [3:0] OP_M2     = 4'd5;
	localparam logic [3:0] OP_M3     = 4'd6;
	localparam logic [3:0] OP_M4     = 4'd7;
	localparam logic [3:0] OP_M5     = 4'd8;
	localparam logic [3:0] OP_W0     = 4'd9;
	localparam logic [3:0] OP_W1     = 4'd10;
	localparam logic [3:0] OP_W2     = 4'd11;
	localparam logic [3:0] OP_OUT    = 4'd12;

	typedef struct packed {
		logic signed [23:0] sample_in;
		logic               button_level;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] left_out;
		logic signed [23:0] right_out;
	} out_item_t;

	typedef struct packed {
		logic [3:0]         op;
		logic [BR_BITS-1:0] br;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} stat_t;

	typedef logic signed [15:0] lfo_rom_t [SINE_ENTRIES];

	function automatic logic signed [25:0] rnd15(input logic signed [40:0] p);
		logic signed [40:0] t;
		t = (p + 41'sd16384) >>> 15;
		return t[25:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
		if (v > 27'sd8388607)
			return 24'sh7FFFFF;
		if (v < -27'sd8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	// sine by polynomial, then scaled by the 0.9 modulation depth
	function automatic lfo_rom_t build_lfo_rom();
		lfo_rom_t rom;
		longint   u, q, r, m, x, x2, t, s, v, a;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			u  = 4 * longint'(k);
			q  = u / SINE_ENTRIES;
			r  = u % SINE_ENTRIES;
			m  = (q % 2 == 1) ? longint'(SINE_ENTRIES) - r : r;
			x  = (longint'(1686629713) * m) / SINE_ENTRIES;
			x2 = (x * x) >>> 30;
			t  = longint'(1) << 30;
			t  = (longint'(1) << 30) - ((x2 * t) >>> 30) / 110;
			t  = (longint'(1) << 30) - ((x2 * t) >>> 30) / 72;
			t  = (longint'(1) << 30) - ((x2 * t) >>> 30) / 42;
			t  = (longint'(1) << 30) - ((x2 * t) >>> 30) / 20;
			t  = (longint'(1) << 30) - ((x2 * t) >>> 30) / 6;
			s  = (x * t) >>> 30;
			v  = (s + 16384) >>> 15;
			if (v > 32767)
				v = 32767;
			if (q >= 2)
				v = -v;
			a = (longint'(29491) * v + 16384) >>> 15;
			rom[k] = a[15:0];
		end
		return rom;
	endfunction

endpackage

// ===== sv/mcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcr_ctrl
// Sequencer: walks the four branches through the shared multiplier.
// ----------------------------------------------------------------------------
module mcr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           out_stall,
	input  mcr_pkg::stat_t stat,
	output mcr_pkg::cmd_t  cmd
);
	import mcr_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_RD1  = 4'd2;
	localparam logic [3:0] ST_M1   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_M3   = 4'd5;
	localparam logic [3:0] ST_M4   = 4'd6;
	localparam logic [3:0] ST_M5   = 4'd7;
	localparam logic [3:0] ST_W0   = 4'd8;
	localparam logic [3:0] ST_W1   = 4'd9;
	localparam logic [3:0] ST_W2   = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	logic [3:0]         state_q, state_d;
	logic [BR_BITS-1:0] br_q, br_d;
	logic               can_load;

	assign in_stall = (state_q != ST_IDLE);
	assign can_load = !stat.out_full || !out_stall;
	assign cmd.br   = br_q;

	always_comb begin
		state_d = state_q;
		br_d    = br_q;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = ST_RD0;
					br_d    = '0;
				end
			end
			ST_RD0: begin cmd.op = OP_RD0; state_d = ST_RD1; end
			ST_RD1: begin cmd.op = OP_RD1; state_d = ST_M1; end
			ST_M1:  begin cmd.op = OP_M1;  state_d = ST_M2; end
			ST_M2:  begin cmd.op = OP_M2;  state_d = ST_M3; end
			ST_M3:  begin cmd.op = OP_M3;  state_d = ST_M4; end
			ST_M4:  begin cmd.op = OP_M4;  state_d = ST_M5; end
			ST_M5: begin
				cmd.op = OP_M5;
				if (br_q == BR_BITS'(BRANCHES - 1)) begin
					state_d = ST_W0;
				end else begin
					state_d = ST_RD0;
					br_d    = br_q + 1'b1;
				end
			end
			ST_W0:  begin cmd.op = OP_W0; state_d = ST_W1; end
			ST_W1:  begin cmd.op = OP_W1; state_d = ST_W2; end
			ST_W2:  begin cmd.op = OP_W2; state_d = ST_OUT; end
			ST_OUT: begin
				if (can_load) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			br_q    <= '0;
		end else begin
			state_q <= state_d;
			br_q    <= br_d;
		end
	end

endmodule

// ===== sv/mcr_datapath.sv =====
// ----------------------------------------------------------------------------
// mcr_datapath
// Config registers, delay lines, LFOs, shared multiplier and output register.
// ----------------------------------------------------------------------------
module mcr_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  mcr_pkg::cmd_t      cmd,
	output mcr_pkg::stat_t     stat,
	input  mcr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mcr_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import mcr_pkg::*;

	localparam lfo_rom_t LFO_ROM = build_lfo_rom();

	logic [63:0] delays_q, steps_q;
	logic [14:0] fb_q, lpb_q, norm_q, gain_q;

	logic signed [23:0] lp_mem  [BRANCHES*LINE_DEPTH];
	logic signed [23:0] out_mem [BRANCHES*LINE_DEPTH];

	logic [LINE_BITS-1:0]  w_q;
	logic                  wrapped_q;
	logic [PHASE_BITS-1:0] phase_q [BRANCHES];
	logic                  reverb_q, last_btn_q;
	logic signed [23:0]    x_q;

	logic [15:0]           d_raw;
	logic [LINE_BITS-1:0]  d_clamp, r_idx, wprev;
	logic [ADDR_BITS-1:0]  lp_raddr;
	logic [LINE_BITS-1:0]  lp_ridx;
	logic                  lp_rvalid;
	logic signed [23:0]    lp_rd_q, out_rd_q;
	logic                  lv_q, ov_q;
	logic signed [15:0]    rom_rd_q;

	logic signed [23:0] out_r_q, lp_r_q, tmp_q, lp_q;
	logic signed [15:0] a_q;
	logic signed [25:0] acc_q;
	logic signed [23:0] br_val_q [BRANCHES];
	logic signed [23:0] left_q, right_q;

	logic signed [15:0] mc;
	logic signed [24:0] md;
	logic signed [40:0] p_q;
	logic signed [25:0] pr;
	logic signed [23:0] lp_new, o_new;
	logic signed [24:0] sum25;
	logic signed [23:0] out_rm, lp_pm;

	logic               out_valid_q;
	out_item_t          out_q;

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.out_full = out_valid_q;

	// read index per branch
	assign d_raw = delays_q[16*cmd.br +: 16];
	always_comb begin
		if (d_raw == 16'd0)
			d_clamp = LINE_BITS'(1);
		else if ({1'b0, d_raw} > 17'(LINE_DEPTH - 1))
			d_clamp = LINE_BITS'(LINE_DEPTH - 1);
		else
			d_clamp = d_raw[LINE_BITS-1:0];
	end
	assign r_idx    = w_q - d_clamp;
	assign wprev    = w_q - 1'b1;
	assign lp_ridx  = (cmd.op == OP_RD0) ? r_idx : wprev;
	assign lp_raddr = {cmd.br, lp_ridx};
	assign lp_rvalid = wrapped_q || (lp_ridx < w_q);

	// entries not yet written since reset read as zero
	always_ff @(posedge clk) begin
		if (cmd.op == OP_M3)
			lp_mem[{cmd.br, w_q}] <= lp_new;
		lp_rd_q <= lp_mem[lp_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_M5)
			out_mem[{cmd.br, w_q}] <= o_new;
		out_rd_q <= out_mem[{cmd.br, r_idx}];
	end

	always_ff @(posedge clk) begin
		rom_rd_q <= LFO_ROM[phase_q[cmd.br][PHASE_BITS-1 -: SINE_BITS]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			lv_q <= lp_rvalid;
			ov_q <= wrapped_q || (r_idx < w_q);
		end
	end

	assign out_rm = ov_q ? out_rd_q : 24'sd0;
	assign lp_pm  = lv_q ? lp_rd_q : 24'sd0;
	assign pr     = rnd15(p_q);
	assign sum25  = 25'(27'(tmp_q) + 27'(pr));
	assign lp_new = sat24(27'(pr));
	assign o_new  = sat24(27'(acc_q) - 27'(pr));

	always_comb begin
		mc = '0;
		md = '0;
		case (cmd.op)
			OP_RD1: begin mc = {1'b0, fb_q};   md = 25'(out_rm); end
			OP_M1:  begin mc = {1'b0, lpb_q};  md = 25'(lp_pm); end
			OP_M2:  begin mc = {1'b0, norm_q}; md = sum25; end
			OP_M3:  begin mc = a_q;            md = 25'(out_r_q); end
			OP_M4:  begin mc = a_q;            md = 25'(lp_q); end
			OP_W0:  begin mc = {1'b0, gain_q}; md = 25'(br_val_q[0]) - 25'(br_val_q[2]); end
			OP_W1:  begin mc = {1'b0, gain_q}; md = 25'(br_val_q[1]) - 25'(br_val_q[3]); end
			default: begin mc = '0; md = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mc * md;
		case (cmd.op)
			OP_ACCEPT: x_q <= in_data.sample_in;
			OP_RD1: begin
				out_r_q <= out_rm;
				lp_r_q  <= lv_q ? lp_rd_q : 24'sd0;
				a_q     <= rom_rd_q;
			end
			OP_M1: tmp_q <= sat24(27'(x_q) + 27'(pr));
			OP_M3: lp_q  <= lp_new;
			OP_M4: acc_q <= 26'(lp_r_q) + pr;
			OP_M5: br_val_q[cmd.br] <= o_new;
			OP_W1: left_q  <= sat24(27'(pr));
			OP_W2: right_q <= sat24(27'(pr));
			OP_OUT: begin
				if (reverb_q)
					out_q <= '{left_out: left_q, right_out: right_q};
				else
					out_q <= '{left_out: x_q, right_out: x_q};
			end
			default: ;
		endcase
	end

	// lp_r is captured in RD1 from the read issued in RD0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= '0;
			wrapped_q   <= 1'b0;
			reverb_q    <= 1'b0;
			last_btn_q  <= 1'b1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < BRANCHES; i++)
				phase_q[i] <= '0;
		end else begin
			if (out_valid_q && !out_stall && cmd.op != OP_OUT)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_ACCEPT: begin
					if (!in_data.button_level && last_btn_q)
						reverb_q <= !reverb_q;
					last_btn_q <= in_data.button_level;
				end
				OP_RD0: phase_q[cmd.br] <= phase_q[cmd.br] +
					PHASE_BITS'(steps_q[16*cmd.br +: 16]);
				OP_OUT: begin
					out_valid_q <= 1'b1;
					w_q         <= w_q + 1'b1;
					if (w_q == LINE_BITS'(LINE_DEPTH - 1))
						wrapped_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q <= DELAYS_RESET;
			steps_q  <= '0;
			fb_q     <= FB_RESET;
			lpb_q    <= LPB_RESET;
			norm_q   <= NORM_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAYS: delays_q <= cfg_data;
				REG_STEPS:  steps_q  <= cfg_data;
				REG_FB:     fb_q     <= cfg_data[14:0];
				REG_LPB:    lpb_q    <= cfg_data[14:0];
				REG_NORM:   norm_q   <= cfg_data[14:0];
				REG_GAIN:   gain_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/modulated_comb_reverb.sv =====
// ----------------------------------------------------------------------------
// modulated_comb_reverb
// Four-branch low-pass feedback comb reverb with LFO modulation and bypass.
// ----------------------------------------------------------------------------
// Each sample runs through one shared 16x25 multiplier, used five times per
// branch in the steps RD0, RD1 and M1 to M5 of each of the four branches,
// then W0 to W2 for the two wet-gain products and OUT to load the output
// register. The next transfer is taken the cycle after the result is loaded,
// and no new sample is taken while one is in progress; a stalled result
// holds the sequencer at its last step. No clearing pass after reset:
// unwritten delay-line entries read as zero by tracking the write pointer's
// first lap.
module modulated_comb_reverb (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mcr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mcr_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import mcr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mcr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
